// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define HBP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked check that applies only while reset is held.
`define HBP_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) (!rst_n) |-> (prop)) else $error(msg);

`endif

// ===== hdl/hbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

	localparam int MAX_BUCKETS      = 256;
	localparam int SLOTS_PER_BUCKET = 16;
	localparam int BKT_W            = $clog2(MAX_BUCKETS);
	localparam int SLOT_W           = $clog2(SLOTS_PER_BUCKET);
	localparam int FILL_W           = SLOT_W + 1;
	localparam int ADDR_W           = BKT_W + SLOT_W;
	localparam int STORE_DEPTH      = MAX_BUCKETS * SLOTS_PER_BUCKET;
	localparam int SIG_W            = 64;
	localparam int VAL_W            = 32;
	localparam int ENTRY_W          = 2 * SIG_W + VAL_W;
	localparam int CNT_W            = 9;
	localparam int OP_W             = 2;
	localparam int STAT_W           = 2;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_READ   = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_DUP  = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	// entry store access: {high, low, value}
	typedef struct packed {
		logic               en;
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] wdata;
	} entry_req_t;

	// fill count store access
	typedef struct packed {
		logic              en;
		logic              we;
		logic [BKT_W-1:0]  addr;
		logic [FILL_W-1:0] wdata;
	} fill_req_t;

endpackage

`default_nettype wire

// ===== hdl/hbp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Single port synchronous RAM, registered read.
module hbp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   addr,
	input  wire logic [WIDTH-1:0]           wdata,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hbp_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bucket count register and multiply-shift bucket map.
module hbp_mapper (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [hbp_pkg::CNT_W-1:0]   cfg_wr_data,
	input  wire logic [hbp_pkg::SIG_W-1:0]   sig_high,
	output logic      [hbp_pkg::BKT_W-1:0]   bucket_s1
);

	import hbp_pkg::*;

	localparam int PROD_W = SIG_W + CNT_W + 1;

	logic [CNT_W-1:0]  bucket_count_q;
	logic [CNT_W-1:0]  n_eff;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-SIG_W-1:0] raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CNT_W'(1);
		end else if (cfg_wr_en) begin
			bucket_count_q <= cfg_wr_data;
		end
	end

	// zero behaves as one, anything past the table size saturates
	always_comb begin
		if (bucket_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (bucket_count_q > CNT_W'(MAX_BUCKETS)) begin
			n_eff = CNT_W'(MAX_BUCKETS);
		end else begin
			n_eff = bucket_count_q;
		end
	end

	// (high >> 1) * (2n), keep bits from 64 up
	assign prod = PROD_W'(sig_high[SIG_W-1:1]) * PROD_W'({n_eff, 1'b0});
	assign raw  = prod[PROD_W-1:SIG_W];

	always_ff @(posedge clk) begin
		if (raw >= (PROD_W-SIG_W)'(MAX_BUCKETS)) begin
			bucket_s1 <= BKT_W'(MAX_BUCKETS - 1);
		end else begin
			bucket_s1 <= raw[BKT_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/hbp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Operation sequencer: fill lookup, slot scan, write-back, entry read, clear, result register.
module hbp_seq (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire hbp_pkg::op_t                  operation,
	input  wire logic [hbp_pkg::SIG_W-1:0]     signature_high,
	input  wire logic [hbp_pkg::SIG_W-1:0]     signature_low,
	input  wire logic [hbp_pkg::VAL_W-1:0]     entry_value,
	input  wire logic [hbp_pkg::BKT_W-1:0]     read_bucket,
	input  wire logic [hbp_pkg::SLOT_W-1:0]    read_slot,
	output logic      [hbp_pkg::SIG_W-1:0]     map_sig,
	input  wire logic [hbp_pkg::BKT_W-1:0]     map_bucket,
	output hbp_pkg::entry_req_t                entry_req,
	input  wire logic [hbp_pkg::ENTRY_W-1:0]   entry_rdata,
	output hbp_pkg::fill_req_t                 fill_req,
	input  wire logic [hbp_pkg::FILL_W-1:0]    fill_rdata,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic      [hbp_pkg::BKT_W-1:0]     bucket_number,
	output logic      [hbp_pkg::SLOT_W-1:0]    slot_number,
	output hbp_pkg::status_t                   status,
	output logic      [hbp_pkg::SIG_W-1:0]     stored_high,
	output logic      [hbp_pkg::SIG_W-1:0]     stored_low,
	output logic      [hbp_pkg::VAL_W-1:0]     stored_value,
	output logic      [hbp_pkg::FILL_W-1:0]    bucket_fill
);

	import hbp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAP   = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_FWAIT = 3'd3;
	localparam logic [2:0] S_SCAN  = 3'd4;
	localparam logic [2:0] S_RDREQ = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]             state_q;
	op_t                    op_q;
	logic [SIG_W-1:0]       sh_q;
	logic [SIG_W-1:0]       sl_q;
	logic [VAL_W-1:0]       val_q;
	logic [BKT_W-1:0]       rb_q;
	logic [SLOT_W-1:0]      rs_q;
	logic [BKT_W-1:0]       bucket_q;
	logic [FILL_W-1:0]      fill_q;
	logic [FILL_W-1:0]      issue_q;
	logic                   found_q;
	logic [SLOT_W-1:0]      dup_slot_q;
	logic                   cmp_vld_s1;
	logic [SLOT_W-1:0]      cmp_slot_s1;
	logic                   fvld_s1;
	logic [MAX_BUCKETS-1:0] fvalid_q;
	logic                   res_valid_q;
	logic [BKT_W-1:0]       res_bucket_q;
	logic [SLOT_W-1:0]      res_slot_q;
	status_t                res_status_q;
	logic [SIG_W-1:0]       res_high_q;
	logic [SIG_W-1:0]       res_low_q;
	logic [VAL_W-1:0]       res_value_q;
	logic [FILL_W-1:0]      res_fill_q;

	logic                   accept;
	logic                   out_free;
	logic                   finish;
	logic                   issuing;
	logic                   sig_match;
	logic                   room;
	logic                   do_write;
	logic [FILL_W-1:0]      rd_fill;

	assign accept    = item_valid && (state_q == S_IDLE);
	assign out_free  = !res_valid_q || !result_stall;
	assign finish    = (state_q == S_DONE) && out_free;
	assign issuing   = (state_q == S_SCAN) && (issue_q < fill_q) && !found_q;
	assign sig_match = cmp_vld_s1 && !found_q &&
		(entry_rdata[ENTRY_W-1:VAL_W] == {sh_q, sl_q});
	assign room      = fill_q < FILL_W'(SLOTS_PER_BUCKET);
	assign do_write  = finish && (op_q == OP_INSERT) && !found_q && room;
	assign rd_fill   = fvld_s1 ? fill_rdata : '0;

	assign item_stall = (state_q != S_IDLE);
	assign map_sig    = sh_q;

	always_comb begin
		entry_req.en    = issuing || do_write || (state_q == S_RDREQ);
		entry_req.we    = do_write;
		entry_req.wdata = {sh_q, sl_q, val_q};
		if (do_write) begin
			entry_req.addr = {bucket_q, fill_q[SLOT_W-1:0]};
		end else if (state_q == S_RDREQ) begin
			entry_req.addr = {rb_q, rs_q};
		end else begin
			entry_req.addr = {bucket_q, issue_q[SLOT_W-1:0]};
		end
	end

	always_comb begin
		fill_req.en    = (state_q == S_FILL) || (state_q == S_RDREQ) || do_write;
		fill_req.we    = do_write;
		fill_req.wdata = fill_q + FILL_W'(1);
		if (state_q == S_FILL) begin
			fill_req.addr = map_bucket;
		end else if (state_q == S_RDREQ) begin
			fill_req.addr = rb_q;
		end else begin
			fill_req.addr = bucket_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			fvalid_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= issuing;
			if (sig_match) begin
				found_q <= 1'b1;
			end
			// a finishing item refills the output register as the old one leaves
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						case (operation)
							OP_INSERT: state_q <= S_MAP;
							OP_READ:   state_q <= S_RDREQ;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_MAP:   state_q <= S_FILL;
				S_FILL:  state_q <= S_FWAIT;
				S_FWAIT: state_q <= S_SCAN;
				S_SCAN: begin
					if (!issuing && !cmp_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_RDREQ: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (op_q == OP_CLEAR) begin
							fvalid_q <= '0;
						end else if (do_write) begin
							fvalid_q[bucket_q] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			sh_q  <= signature_high;
			sl_q  <= signature_low;
			val_q <= entry_value;
			rb_q  <= read_bucket;
			rs_q  <= read_slot;
		end
		if (fill_req.en && !fill_req.we) begin
			fvld_s1 <= fvalid_q[fill_req.addr];
		end
		if (state_q == S_FILL) begin
			bucket_q <= map_bucket;
		end
		if (state_q == S_FWAIT) begin
			fill_q  <= rd_fill;
			issue_q <= '0;
		end
		if (issuing) begin
			issue_q     <= issue_q + FILL_W'(1);
			cmp_slot_s1 <= issue_q[SLOT_W-1:0];
		end
		if (sig_match) begin
			dup_slot_q <= cmp_slot_s1;
		end
		if (finish) begin
			res_bucket_q <= '0;
			res_slot_q   <= '0;
			res_status_q <= ST_OK;
			res_high_q   <= '0;
			res_low_q    <= '0;
			res_value_q  <= '0;
			res_fill_q   <= '0;
			case (op_q)
				OP_INSERT: begin
					res_bucket_q <= bucket_q;
					if (found_q) begin
						res_status_q <= ST_DUP;
						res_slot_q   <= dup_slot_q;
						res_fill_q   <= fill_q;
					end else if (!room) begin
						res_status_q <= ST_FULL;
						res_fill_q   <= fill_q;
					end else begin
						res_slot_q <= fill_q[SLOT_W-1:0];
						res_fill_q <= fill_q + FILL_W'(1);
					end
				end
				OP_READ: begin
					res_bucket_q <= rb_q;
					res_slot_q   <= rs_q;
					res_fill_q   <= rd_fill;
					if ({1'b0, rs_q} < rd_fill) begin
						res_high_q  <= entry_rdata[ENTRY_W-1:SIG_W+VAL_W];
						res_low_q   <= entry_rdata[SIG_W+VAL_W-1:VAL_W];
						res_value_q <= entry_rdata[VAL_W-1:0];
					end
				end
				default: begin
					res_status_q <= ST_OK;
				end
			endcase
		end
	end

	assign result_valid  = res_valid_q;
	assign bucket_number = res_bucket_q;
	assign slot_number   = res_slot_q;
	assign status        = res_status_q;
	assign stored_high   = res_high_q;
	assign stored_low    = res_low_q;
	assign stored_value  = res_value_q;
	assign bucket_fill   = res_fill_q;

endmodule

`default_nettype wire

// ===== hdl/hash_bucket_partitioner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hash bucket partitioner. Each item is an insert, a read or a clear.
// An insert maps signature_high to one of bucket_count buckets by
// multiply-shift, reads that bucket's fill count, then walks its filled
// slots through the entry RAM one read per cycle looking for an equal
// 128-bit signature (status 1, slot of the match). With no match and room
// left the entry is appended (status 0); a full bucket gives status 2.
// A read returns the addressed entry and the bucket's fill (zeros past the
// fill); a clear empties every bucket at once. One item is worked on at a
// time: an insert walks the bucket slot by slot through the single read
// port of the entry RAM, and a duplicate cuts the walk short. The result
// sits in an output register, so the next item is taken while a finished
// result still waits. The user must see that bucket_count is written only
// while the block is idle; the block itself does not enforce it. No
// clearing pass is needed after reset as per-bucket valid bits, kept in
// the sequencer, qualify the fill counts.
module hash_bucket_partitioner_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [hbp_pkg::CNT_W-1:0]     cfg_wr_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire hbp_pkg::op_t                  operation,
	input  wire logic [hbp_pkg::SIG_W-1:0]     signature_high,
	input  wire logic [hbp_pkg::SIG_W-1:0]     signature_low,
	input  wire logic [hbp_pkg::VAL_W-1:0]     entry_value,
	input  wire logic [hbp_pkg::BKT_W-1:0]     read_bucket,
	input  wire logic [hbp_pkg::SLOT_W-1:0]    read_slot,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic      [hbp_pkg::BKT_W-1:0]     bucket_number,
	output logic      [hbp_pkg::SLOT_W-1:0]    slot_number,
	output hbp_pkg::status_t                   status,
	output logic      [hbp_pkg::SIG_W-1:0]     stored_high,
	output logic      [hbp_pkg::SIG_W-1:0]     stored_low,
	output logic      [hbp_pkg::VAL_W-1:0]     stored_value,
	output logic      [hbp_pkg::FILL_W-1:0]    bucket_fill
);

	import hbp_pkg::*;

	logic [SIG_W-1:0]   map_sig;
	logic [BKT_W-1:0]   map_bucket;
	entry_req_t         entry_req;
	logic [ENTRY_W-1:0] entry_rdata;
	fill_req_t          fill_req;
	logic [FILL_W-1:0]  fill_rdata;

	// bucket map, registered; ready in the cycle after the signature is latched
	hbp_mapper u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sig_high    (map_sig),
		.bucket_s1   (map_bucket)
	);

	// signature and value store: bucket-major, slot-minor
	hbp_ram #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (ENTRY_W)
	) u_entry_ram (
		.clk   (clk),
		.en    (entry_req.en),
		.we    (entry_req.we),
		.addr  (entry_req.addr),
		.wdata (entry_req.wdata),
		.rdata (entry_rdata)
	);

	// fill count per bucket; validity tracked in the sequencer
	hbp_ram #(
		.DEPTH (MAX_BUCKETS),
		.WIDTH (FILL_W)
	) u_fill_ram (
		.clk   (clk),
		.en    (fill_req.en),
		.we    (fill_req.we),
		.addr  (fill_req.addr),
		.wdata (fill_req.wdata),
		.rdata (fill_rdata)
	);

	hbp_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.operation      (operation),
		.signature_high (signature_high),
		.signature_low  (signature_low),
		.entry_value    (entry_value),
		.read_bucket    (read_bucket),
		.read_slot      (read_slot),
		.map_sig        (map_sig),
		.map_bucket     (map_bucket),
		.entry_req      (entry_req),
		.entry_rdata    (entry_rdata),
		.fill_req       (fill_req),
		.fill_rdata     (fill_rdata),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.bucket_number  (bucket_number),
		.slot_number    (slot_number),
		.status         (status),
		.stored_high    (stored_high),
		.stored_low     (stored_low),
		.stored_value   (stored_value),
		.bucket_fill    (bucket_fill)
	);

endmodule

`default_nettype wire

// ===== hdl/hbp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the partitioner.
module hbp_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	input  wire logic                          item_stall,
	input  wire logic                          result_valid,
	input  wire logic                          result_stall,
	input  wire logic [hbp_pkg::SLOT_W-1:0]    slot_number,
	input  wire hbp_pkg::status_t              status,
	input  wire logic [hbp_pkg::SIG_W-1:0]     stored_high,
	input  wire logic [hbp_pkg::FILL_W-1:0]    bucket_fill
);

	import hbp_pkg::*;

	`HBP_ASSERT_RST(a_reset_quiet, clk, arst_n, !result_valid && !item_stall, "outputs active in reset")

	// one item in flight: acceptance always closes the input
	`HBP_ASSERT(a_accept_busy, clk, arst_n, item_valid && !item_stall |=> item_stall, "input open after accept")

	`HBP_ASSERT(a_hold, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(status) && $stable(stored_high) && $stable(bucket_fill), "stalled item changed")

	`HBP_ASSERT(a_full, clk, arst_n, result_valid && status == ST_FULL |-> bucket_fill == FILL_W'(SLOTS_PER_BUCKET) && slot_number == '0, "full bucket result wrong")

	`HBP_ASSERT(a_dup, clk, arst_n, result_valid && status == ST_DUP |-> {1'b0, slot_number} < bucket_fill, "duplicate slot past fill")

endmodule

bind hash_bucket_partitioner_top hbp_checker u_chk (.*);

`default_nettype wire
